@@ rtl/gapr_pkg.sv @@
// Shared constants for the gated average pressure rise detector.
`default_nettype none

package gapr_pkg;

   // Field widths
   localparam int unsigned SAMPLE_W    = 24;
   localparam int unsigned COUNT_W     = 8;
   localparam int unsigned CODE_W      = 2;
   localparam int unsigned CSR_INDEX_W = 2;

   // Window depth default
   localparam int unsigned DEFAULT_WINDOW_DEPTH = 8;

   // Signal codes
   localparam logic [CODE_W-1:0] CODE_OFF  = 2'd0;
   localparam logic [CODE_W-1:0] CODE_ON   = 2'd1;
   localparam logic [CODE_W-1:0] CODE_IDLE = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_GATE_BAND        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RISE_THRESHOLD   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFF_REPEAT_COUNT = 2'd2;

   // Register reset values
   localparam logic [SAMPLE_W-1:0] GATE_BAND_RESET        = 24'd500;
   localparam logic [SAMPLE_W-1:0] RISE_THRESHOLD_RESET   = 24'd1000;
   localparam logic [COUNT_W-1:0]  OFF_REPEAT_COUNT_RESET = 8'd3;

endpackage

`default_nettype wire

@@ rtl/gapr_window_mem.sv @@
// Sample window memory: one port, synchronous registered read.
`default_nettype none

module gapr_window_mem #(
   parameter int unsigned DEPTH  = gapr_pkg::DEFAULT_WINDOW_DEPTH,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic                          rd_en,
   input  wire logic [ADDR_W-1:0]             addr,
   input  wire logic [gapr_pkg::SAMPLE_W-1:0] wr_data,
   output logic      [gapr_pkg::SAMPLE_W-1:0] rd_data
);

   logic [gapr_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic [gapr_pkg::SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/gapr_mean_div.sv @@
// Reciprocal multiplier that turns the window sum into its floor mean.
`default_nettype none

module gapr_mean_div #(
   parameter int unsigned DIVISOR = gapr_pkg::DEFAULT_WINDOW_DEPTH,
   parameter int unsigned SUM_W   = gapr_pkg::SAMPLE_W + $clog2(DIVISOR)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [SUM_W-1:0]              dividend,
   output logic                               done,
   output logic      [gapr_pkg::SAMPLE_W-1:0] quotient
);

   // Multiply by ceil(2^SHIFT / DIVISOR) and drop SHIFT bits; exact for every
   // SUM_W-bit sum since 2^clog2(DIVISOR) is at least DIVISOR
   localparam int unsigned SHIFT   = SUM_W + $clog2(DIVISOR);
   localparam int unsigned RECIP_W = SUM_W + 1;
   localparam int unsigned PROD_W  = SHIFT + gapr_pkg::SAMPLE_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

   logic [PROD_W-1:0]             product;
   logic [gapr_pkg::SAMPLE_W-1:0] quo_ff;
   logic                          done_ff;

   assign product = PROD_W'(dividend) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= product[PROD_W-1 -: gapr_pkg::SAMPLE_W];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ rtl/gated_average_pressure_rise_detector_unit.sv @@
// Processes one pressure sample at a time; for each accepted item one result
// item is produced. An item passes the gate, window update (only when the
// sample is stored in the window), divider start, divider wait and detect
// steps in that order. The mean comes from a running window sum and a
// registered reciprocal multiply by the window depth. An item that refills
// the window (the first after reset, or one with restart set) first takes a
// fill sweep that writes it to every entry through the single window memory
// port. A new item is accepted as soon as the previous one has been handed to
// the output register; a result still stalled at the output holds the
// following item in its detect step.
`default_nettype none

module gated_average_pressure_rise_detector_unit #(
   parameter int unsigned WINDOW_DEPTH = gapr_pkg::DEFAULT_WINDOW_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Configuration
   input  wire logic                             csr_wr_en,
   input  wire logic [gapr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [gapr_pkg::SAMPLE_W-1:0]    csr_wr_data,
   // Sample input
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [gapr_pkg::SAMPLE_W-1:0]    req_pressure_sample,
   input  wire logic                             req_restart,
   // Result output
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic      [gapr_pkg::CODE_W-1:0]      rsp_signal_code,
   output logic      [gapr_pkg::SAMPLE_W-1:0]    rsp_mean_value,
   output logic                                  rsp_detecting,
   output logic                                  rsp_rise_event
);

   localparam int unsigned SW     = gapr_pkg::SAMPLE_W;
   localparam int unsigned CW     = gapr_pkg::COUNT_W;
   localparam int unsigned ADDR_W = $clog2(WINDOW_DEPTH);
   localparam int unsigned WIDX_W = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned SUM_W  = SW + $clog2(WINDOW_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FILL,
      S_GATE,
      S_UPDATE,
      S_DIV_GO,
      S_DIV_WAIT,
      S_DETECT
   } state_type;

   function automatic logic in_band(input logic [SW-1:0] smp,
                                    input logic [SW-1:0] mean,
                                    input logic [SW-1:0] band);
      logic [SW:0]   hi;
      logic [SW-1:0] lo;
      hi = {1'b0, mean} + {1'b0, band};
      lo = (mean > band) ? (mean - band) : '0;
      return ({1'b0, smp} < hi) && (smp > lo);
   endfunction

   // Configuration registers
   logic [SW-1:0] gate_band_ff;
   logic [SW-1:0] rise_threshold_ff;
   logic [CW-1:0] off_repeat_count_ff;

   // Control and window state
   state_type             state_ff;
   logic [SW-1:0]         sample_ff;
   logic [SW-1:0]         mean_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [WIDX_W-1:0]     wr_idx_ff;
   logic [ADDR_W-1:0]     fill_addr_ff;
   logic                  needs_fill_ff;
   logic                  active_ff;
   logic                  off_pending_ff;
   logic [CW-1:0]         off_sent_ff;
   logic [gapr_pkg::CODE_W-1:0] held_code_ff;

   // Output register
   logic                        rsp_valid_ff;
   logic [gapr_pkg::CODE_W-1:0] rsp_code_ff;
   logic [SW-1:0]               rsp_mean_ff;
   logic                        rsp_detecting_ff;
   logic                        rsp_rise_ff;

   // Memory and divider hookup
   logic              mem_wr_en;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_addr;
   logic [SW-1:0]     mem_rd_data;
   logic              div_done;
   logic [SW-1:0]     div_quotient;

   // Detection next state
   logic                        gate_hit;
   logic                        active_in;
   logic                        off_pending_in;
   logic [CW-1:0]               off_sent_in;
   logic [gapr_pkg::CODE_W-1:0] held_code_in;
   logic                        rise_in;
   logic                        out_free;

   assign gate_hit  = in_band(sample_ff, mean_ff, gate_band_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign mem_wr_en = (state_ff == S_FILL) || (state_ff == S_UPDATE);
   assign mem_rd_en = (state_ff == S_GATE) && (wr_idx_ff != WIDX_W'(WINDOW_DEPTH)) && gate_hit;
   assign mem_addr  = (state_ff == S_FILL) ? fill_addr_ff : wr_idx_ff[ADDR_W-1:0];

   // Detector decision, using the freshly computed mean
   always_comb begin
      active_in      = active_ff;
      off_pending_in = off_pending_ff;
      off_sent_in    = off_sent_ff;
      held_code_in   = held_code_ff;
      rise_in        = 1'b0;
      if (off_pending_ff) begin
         if (off_sent_ff < off_repeat_count_ff) begin
            held_code_in = gapr_pkg::CODE_OFF;
            off_sent_in  = off_sent_ff + 1'b1;
         end else begin
            held_code_in   = gapr_pkg::CODE_IDLE;
            off_pending_in = 1'b0;
         end
      end
      if ({1'b0, sample_ff} > ({1'b0, mean_ff} + {1'b0, rise_threshold_ff})) begin
         active_in      = 1'b1;
         off_pending_in = 1'b0;
         held_code_in   = gapr_pkg::CODE_ON;
         rise_in        = 1'b1;
      end else if (active_ff && gate_hit) begin
         held_code_in   = gapr_pkg::CODE_OFF;
         active_in      = 1'b0;
         off_sent_in    = '0;
         off_pending_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_band_ff        <= gapr_pkg::GATE_BAND_RESET;
         rise_threshold_ff   <= gapr_pkg::RISE_THRESHOLD_RESET;
         off_repeat_count_ff <= gapr_pkg::OFF_REPEAT_COUNT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            gapr_pkg::CSR_GATE_BAND:        gate_band_ff        <= csr_wr_data;
            gapr_pkg::CSR_RISE_THRESHOLD:   rise_threshold_ff   <= csr_wr_data;
            gapr_pkg::CSR_OFF_REPEAT_COUNT: off_repeat_count_ff <= csr_wr_data[CW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         wr_idx_ff      <= '0;
         mean_ff        <= '0;
         needs_fill_ff  <= 1'b1;
         active_ff      <= 1'b0;
         off_pending_ff <= 1'b0;
         off_sent_ff    <= '0;
         held_code_ff   <= gapr_pkg::CODE_IDLE;
         rsp_valid_ff   <= 1'b0;
         fill_addr_ff   <= '0;
      end else begin
         if ((state_ff == S_DETECT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  sample_ff <= req_pressure_sample;
                  if (needs_fill_ff || req_restart) begin
                     mean_ff       <= req_pressure_sample;
                     wr_idx_ff     <= '0;
                     needs_fill_ff <= 1'b0;
                     fill_addr_ff  <= '0;
                     sum_ff        <= '0;
                     state_ff      <= S_FILL;
                  end else begin
                     state_ff <= S_GATE;
                  end
               end
            end
            S_FILL: begin
               sum_ff       <= sum_ff + SUM_W'(sample_ff);
               fill_addr_ff <= fill_addr_ff + 1'b1;
               if (fill_addr_ff == ADDR_W'(WINDOW_DEPTH - 1)) begin
                  state_ff <= S_GATE;
               end
            end
            S_GATE: begin
               if (wr_idx_ff == WIDX_W'(WINDOW_DEPTH)) begin
                  // Window full: wrap and drop this sample
                  wr_idx_ff <= '0;
                  state_ff  <= S_DIV_GO;
               end else if (gate_hit) begin
                  state_ff <= S_UPDATE;
               end else begin
                  state_ff <= S_DIV_GO;
               end
            end
            S_UPDATE: begin
               // Replace the old entry in the running sum
               sum_ff    <= sum_ff - SUM_W'(mem_rd_data) + SUM_W'(sample_ff);
               wr_idx_ff <= wr_idx_ff + 1'b1;
               state_ff  <= S_DIV_GO;
            end
            S_DIV_GO: begin
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  mean_ff  <= div_quotient;
                  state_ff <= S_DETECT;
               end
            end
            S_DETECT: begin
               if (out_free) begin
                  active_ff        <= active_in;
                  off_pending_ff   <= off_pending_in;
                  off_sent_ff      <= off_sent_in;
                  held_code_ff     <= held_code_in;
                  rsp_code_ff      <= held_code_in;
                  rsp_mean_ff      <= mean_ff;
                  rsp_detecting_ff <= active_in;
                  rsp_rise_ff      <= rise_in;
                  state_ff         <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   gapr_window_mem #(
      .DEPTH  (WINDOW_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_window_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (sample_ff),
      .rd_data (mem_rd_data)
   );

   gapr_mean_div #(
      .DIVISOR (WINDOW_DEPTH),
      .SUM_W   (SUM_W)
   ) u_mean_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_DIV_GO),
      .dividend (sum_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_signal_code = rsp_code_ff;
   assign rsp_mean_value  = rsp_mean_ff;
   assign rsp_detecting   = rsp_detecting_ff;
   assign rsp_rise_event  = rsp_rise_ff;

   // Detection on and code ON always move together
   a_code_tracks_active: assert property (@(posedge clock) disable iff (reset)
      (held_code_ff == gapr_pkg::CODE_ON) == active_ff)
      else $error("held code and active flag disagree");

   a_pending_not_active: assert property (@(posedge clock) disable iff (reset)
      off_pending_ff |-> !active_ff)
      else $error("off repetition pending while detecting");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_idx_ff <= WIDX_W'(WINDOW_DEPTH))
      else $error("write index beyond window depth");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_WAIT))
      else $error("divider finished outside the wait state");

   a_rise_reports_on: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_rise_ff) |-> (rsp_detecting_ff && rsp_code_ff == gapr_pkg::CODE_ON))
      else $error("rise item without detection on");

endmodule

`default_nettype wire
